@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the slot table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/vpst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpst_pkg
// Types and constants shared by the versioned pointer slot table.
// ----------------------------------------------------------------------------
package vpst_pkg;

    localparam int SLOT_COUNT_DEF = 8;
    localparam int VER_W          = 32;
    localparam int PTR_W          = 48;
    localparam int DIST_W         = 30;

    // Slots at this distance or further behind the query do not qualify.
    localparam logic [VER_W-1:0] WINDOW = 32'd1_000_000_000;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_ADD    = 1'b1;

    typedef struct packed {
        logic [VER_W-1:0] ver;
        logic [PTR_W-1:0] ptr;
    } t_slot;

    typedef struct packed {
        logic init;
        logic step;
    } t_scan_ctl;

endpackage

@@ rtl/vpst_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpst_req_if / vpst_rsp_if
// Valid/ready channels carrying request and response transactions.
// ----------------------------------------------------------------------------
interface vpst_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] query_version;
    logic [31:0] min_active;
    logic [47:0] new_pointer;

    modport source (output valid, mode, query_version, min_active, new_pointer,
                    input ready);
    modport sink (input valid, mode, query_version, min_active, new_pointer,
                  output ready);
endinterface

interface vpst_rsp_if;
    logic        valid;
    logic        ready;
    logic [47:0] found_pointer;
    logic        matched;
    logic [31:0] head_version;
    logic [47:0] head_pointer;

    modport source (output valid, found_pointer, matched, head_version, head_pointer,
                    input ready);
    modport sink (input valid, found_pointer, matched, head_version, head_pointer,
                  output ready);
endinterface

@@ rtl/versioned_pointer_slot_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// versioned_pointer_slot_table
// Table of (version, pointer) slots with slot 0 as head; serves lookups by
// version and adds of new head entries, one transaction at a time.
//
//   Channel  Direction  Handshake    Payload
//   i_req    in         valid/ready  mode, query_version, min_active, new_pointer
//   o_rsp    out        valid/ready  found_pointer, matched, head_version, head_pointer
//
// An item is finished before the next one can be accepted: the non-head slots are
// read from the slot memory one per cycle.
// A transaction whose query equals the head version skips the slot scan.
// Reset is synchronous; all slots read as zero afterwards with no clearing pass.
// One finished result is held in the output register while the next request
// is accepted; the block waits only when a second result would overwrite it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module versioned_pointer_slot_table
    import vpst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vpst_req_if.sink   i_req,
    vpst_rsp_if.source o_rsp
);

    localparam int SW        = $clog2(SLOT_COUNT);
    localparam int MEM_DEPTH = SLOT_COUNT - 1;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]       r_state, n_state;
    t_slot            r_head, n_head;
    logic             r_mode, n_mode;
    logic [VER_W-1:0] r_query, n_query;
    logic [PTR_W-1:0] r_new_ptr, n_new_ptr;
    logic [SW-1:0]    r_rd_slot, n_rd_slot;
    logic             r_issuing, n_issuing;
    logic             r_pend, n_pend;
    logic [SW-1:0]    r_pend_slot, n_pend_slot;
    logic             r_pend_last, n_pend_last;
    logic [PTR_W-1:0] r_res_ptr, n_res_ptr;
    logic             r_res_hit, n_res_hit;
    logic             r_out_valid, n_out_valid;
    logic [PTR_W-1:0] r_out_found, n_out_found;
    logic             r_out_matched, n_out_matched;
    t_slot            r_out_head, n_out_head;

    logic             w_accept;
    logic             w_head_hit;
    t_scan_ctl        w_scan_ctl;
    logic             w_rd_en;
    logic [SW-1:0]    w_rd_index;
    logic             w_wr_en;
    logic [SW-1:0]    w_wr_index;
    t_slot            w_rd_data;
    logic [PTR_W-1:0] w_best_ptr;
    logic             w_any;
    logic             w_stale_found;
    logic [SW-1:0]    w_stale_slot;

    vpst_slot_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_index[MEM_AW-1:0]),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_index[MEM_AW-1:0]),
        .i_wr_data (r_head)
    );

    vpst_scan #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_scan_ctl),
        .i_query       (i_req.query_version),
        .i_min_active  (i_req.min_active),
        .i_head        (r_head),
        .i_slot        (r_pend_slot),
        .i_data        (w_rd_data),
        .o_best_ptr    (w_best_ptr),
        .o_any         (w_any),
        .o_stale_found (w_stale_found),
        .o_stale_slot  (w_stale_slot)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_head_hit  = (i_req.query_version == r_head.ver);

    // Slot s lives at memory address s - 1.
    assign w_rd_en    = (r_state == S_SCAN) && r_issuing;
    assign w_rd_index = r_rd_slot - SW'(1);
    assign w_wr_en    = (r_state == S_COMMIT) && (r_mode == MODE_ADD) && w_stale_found;
    assign w_wr_index = w_stale_slot - SW'(1);

    assign w_scan_ctl.init = w_accept && !w_head_hit;
    assign w_scan_ctl.step = r_pend;

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_mode        = r_mode;
        n_query       = r_query;
        n_new_ptr     = r_new_ptr;
        n_rd_slot     = r_rd_slot;
        n_issuing     = r_issuing;
        n_pend        = w_rd_en;
        n_pend_slot   = r_rd_slot;
        n_pend_last   = (r_rd_slot == LAST_SLOT);
        n_res_ptr     = r_res_ptr;
        n_res_hit     = r_res_hit;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_found   = r_out_found;
        n_out_matched = r_out_matched;
        n_out_head    = r_out_head;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode    = i_req.mode;
                    n_query   = i_req.query_version;
                    n_new_ptr = i_req.new_pointer;
                    if (w_head_hit) begin
                        if (i_req.mode == MODE_ADD) begin
                            n_head.ptr = i_req.new_pointer;
                            n_res_ptr  = '0;
                            n_res_hit  = 1'b0;
                        end else begin
                            n_res_ptr = r_head.ptr;
                            n_res_hit = 1'b1;
                        end
                        n_state = S_DONE;
                    end else begin
                        n_rd_slot = SW'(1);
                        n_issuing = 1'b1;
                        n_state   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_issuing) begin
                    if (r_rd_slot == LAST_SLOT) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_rd_slot = r_rd_slot + SW'(1);
                    end
                end
                if (r_pend && r_pend_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (r_mode == MODE_ADD) begin
                    n_head.ver = r_query;
                    n_head.ptr = r_new_ptr;
                    n_res_ptr  = '0;
                    n_res_hit  = 1'b0;
                end else begin
                    n_res_ptr = w_best_ptr;
                    n_res_hit = w_any;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_found   = r_res_ptr;
                    n_out_matched = r_res_hit;
                    n_out_head    = r_head;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_issuing   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_issuing   <= n_issuing;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode        <= n_mode;
        r_query       <= n_query;
        r_new_ptr     <= n_new_ptr;
        r_rd_slot     <= n_rd_slot;
        r_pend_slot   <= n_pend_slot;
        r_pend_last   <= n_pend_last;
        r_res_ptr     <= n_res_ptr;
        r_res_hit     <= n_res_hit;
        r_out_found   <= n_out_found;
        r_out_matched <= n_out_matched;
        r_out_head    <= n_out_head;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found_pointer = r_out_found;
    assign o_rsp.matched       = r_out_matched;
    assign o_rsp.head_version  = r_out_head.ver;
    assign o_rsp.head_pointer  = r_out_head.ptr;

    `ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept, r_state != S_IDLE)
    `ASSERT_NXT(a_head_hit_short, i_clk, i_rst_n, w_accept && (i_req.mode == MODE_LOOKUP) && w_head_hit, r_state == S_DONE)
    `ASSERT_IMP(a_read_data_in_scan, i_clk, i_rst_n, r_pend, r_state == S_SCAN)

endmodule

@@ rtl/vpst_slot_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpst_slot_mem
// Storage for the non-head slots, one write and one registered read port.
// ----------------------------------------------------------------------------
module vpst_slot_mem
    import vpst_pkg::*;
#(
    parameter int DEPTH = SLOT_COUNT_DEF - 1,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_slot         o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_slot         i_wr_data
);

    t_slot             mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    t_slot             r_rd_data;
    logic              r_rd_valid;

    // Entries never written read as zero, as after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

@@ rtl/vpst_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpst_scan
// Per-slot compare unit: tracks the closest qualifying slot for a lookup
// and the first stale slot for an add.
// ----------------------------------------------------------------------------
module vpst_scan
    import vpst_pkg::*;
#(
    parameter  int SLOT_COUNT = SLOT_COUNT_DEF,
    localparam int SW         = $clog2(SLOT_COUNT)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [VER_W-1:0] i_query,
    input  logic [VER_W-1:0] i_min_active,
    input  t_slot            i_head,
    input  logic [SW-1:0]    i_slot,
    input  t_slot            i_data,
    output logic [PTR_W-1:0] o_best_ptr,
    output logic             o_any,
    output logic             o_stale_found,
    output logic [SW-1:0]    o_stale_slot
);

    logic [VER_W-1:0]  r_query;
    logic [VER_W-1:0]  r_min_active;
    logic [DIST_W-1:0] r_best_dist;
    logic [PTR_W-1:0]  r_best_ptr;
    logic              r_any;
    logic              r_stale_found;
    logic [SW-1:0]     r_stale_slot;

    logic [VER_W:0]    w_head_diff;
    logic              w_head_qual;
    logic [VER_W:0]    w_step_diff;
    logic              w_step_better;
    logic              w_step_stale;

    always_comb begin
        w_head_diff   = {1'b0, i_query} - {1'b0, i_head.ver};
        w_head_qual   = !w_head_diff[VER_W] && (w_head_diff[VER_W-1:0] < WINDOW);
        w_step_diff   = {1'b0, r_query} - {1'b0, i_data.ver};
        w_step_better = !w_step_diff[VER_W]
                        && (w_step_diff[VER_W-1:0] < {{(VER_W-DIST_W){1'b0}}, r_best_dist});
        w_step_stale  = !r_stale_found && (i_data.ver < r_min_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any         <= 1'b0;
            r_stale_found <= 1'b0;
        end else if (i_ctl.init) begin
            r_any         <= w_head_qual;
            r_stale_found <= 1'b0;
        end else if (i_ctl.step) begin
            if (w_step_better) begin
                r_any <= 1'b1;
            end
            if (w_step_stale) begin
                r_stale_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_query      <= i_query;
            r_min_active <= i_min_active;
            r_best_ptr   <= i_head.ptr;
            r_best_dist  <= w_head_qual ? w_head_diff[DIST_W-1:0] : WINDOW[DIST_W-1:0];
            r_stale_slot <= '0;
        end else if (i_ctl.step) begin
            if (w_step_better) begin
                r_best_dist <= w_step_diff[DIST_W-1:0];
                r_best_ptr  <= i_data.ptr;
            end
            if (w_step_stale) begin
                r_stale_slot <= i_slot;
            end
        end
    end

    assign o_best_ptr    = r_best_ptr;
    assign o_any         = r_any;
    assign o_stale_found = r_stale_found;
    assign o_stale_slot  = r_stale_slot;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for versioned_pointer_slot_table. A behavioural copy of
// the slot table is updated on every accepted request and gives the reply
// that each response transaction must carry. Directed cases cover the table
// corners, then version-ordered traffic runs under three idling patterns and
// one long response stall.
// ----------------------------------------------------------------------------
module tb;
    import vpst_pkg::*;

    localparam int SLOT_N       = SLOT_COUNT_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [PTR_W-1:0] found;
        logic             matched;
        logic [VER_W-1:0] head_ver;
        logic [PTR_W-1:0] head_ptr;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    vpst_req_if req_if ();
    vpst_rsp_if rsp_if ();

    versioned_pointer_slot_table #(
        .SLOT_COUNT(SLOT_N)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    logic [VER_W-1:0] tbl_ver [SLOT_N];
    logic [PTR_W-1:0] tbl_ptr [SLOT_N];
    t_reply           owed_replies [$];
    int               err_count = 0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               hold_req = 0;
    int               quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Applies one request to the table copy and returns the reply it owes.
    function automatic t_reply slot_table_apply(input logic mode, input logic [VER_W-1:0] q,
                                                input logic [VER_W-1:0] ma,
                                                input logic [PTR_W-1:0] p);
        t_reply           r;
        logic [VER_W-1:0] best_dist;
        logic [VER_W-1:0] d;
        int               best;
        int               tgt;
        logic             any;
        r = '0;
        if (mode == MODE_LOOKUP) begin
            if (tbl_ver[0] == q) begin
                r.found   = tbl_ptr[0];
                r.matched = 1'b1;
            end else begin
                best_dist = WINDOW;
                best      = 0;
                any       = 1'b0;
                for (int i = 0; i < SLOT_N; i++) begin
                    if (tbl_ver[i] <= q) begin
                        d = q - tbl_ver[i];
                        if (d < best_dist) begin
                            best_dist = d;
                            best      = i;
                            any       = 1'b1;
                        end
                    end
                end
                r.found   = tbl_ptr[best];
                r.matched = any;
            end
        end else if (tbl_ver[0] == q) begin
            tbl_ptr[0] = p;
        end else begin
            tgt = 0;
            for (int i = 1; i < SLOT_N; i++) begin
                if (tgt == 0 && tbl_ver[i] < ma) begin
                    tgt = i;
                end
            end
            tbl_ptr[tgt] = tbl_ptr[0];
            tbl_ver[tgt] = tbl_ver[0];
            tbl_ptr[0]   = p;
            tbl_ver[0]   = q;
        end
        r.head_ver = tbl_ver[0];
        r.head_ptr = tbl_ptr[0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_N; i++) begin
                tbl_ver[i] = '0;
                tbl_ptr[i] = '0;
            end
        end else begin
            if (req_if.valid && req_if.ready) begin
                owed_replies.push_back(slot_table_apply(req_if.mode, req_if.query_version,
                                                        req_if.min_active,
                                                        req_if.new_pointer));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_replies.size() == 0) begin
                    $display("%0t: response with no request outstanding", $time);
                    err_count++;
                end else begin
                    want = owed_replies.pop_front();
                    if (rsp_if.found_pointer !== want.found) begin
                        $display("%0t: found_pointer expected %h actual %h",
                                 $time, want.found, rsp_if.found_pointer);
                        err_count++;
                    end
                    if (rsp_if.matched !== want.matched) begin
                        $display("%0t: matched expected %b actual %b",
                                 $time, want.matched, rsp_if.matched);
                        err_count++;
                    end
                    if (rsp_if.head_version !== want.head_ver) begin
                        $display("%0t: head_version expected %h actual %h",
                                 $time, want.head_ver, rsp_if.head_version);
                        err_count++;
                    end
                    if (rsp_if.head_pointer !== want.head_ptr) begin
                        $display("%0t: head_pointer expected %h actual %h",
                                 $time, want.head_ptr, rsp_if.head_pointer);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int hold_cnt;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                rsp_if.ready = 1'b0;
                hold_cnt     = hold_req;
                hold_req     = 0;
                while (hold_cnt > 0) begin
                    @(negedge i_clk);
                    hold_cnt--;
                end
            end
            rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic mode, input logic [VER_W-1:0] q,
                             input logic [VER_W-1:0] ma, input logic [PTR_W-1:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid         = 1'b1;
        req_if.mode          = mode;
        req_if.query_version = q;
        req_if.min_active    = ma;
        req_if.new_pointer   = p;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [PTR_W-1:0] any_pointer();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[PTR_W-1:0];
    endfunction

    task automatic test_head_and_fallback();
        send_item(MODE_LOOKUP, 32'd0, 32'hFFFF_FFFF, any_pointer());
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0, any_pointer());
        send_item(MODE_ADD, 32'd0, 32'd0, {PTR_W{1'b1}});
        send_item(MODE_LOOKUP, 32'd0, 32'd0, '0);
    endtask

    task automatic test_slot_reuse();
        send_item(MODE_ADD, 32'd100, 32'd0, 48'h0000_0000_00A1);
        send_item(MODE_ADD, 32'd200, 32'd50, 48'h0000_0000_00B2);
        send_item(MODE_ADD, 32'd300, 32'd50, 48'h0000_0000_00C3);
        send_item(MODE_ADD, 32'd200, 32'hFFFF_FFFF, 48'h8000_0000_00D4);
        send_item(MODE_ADD, 32'd200, 32'd7, 48'h0000_0000_00D5);
    endtask

    task automatic test_ties_and_window();
        send_item(MODE_LOOKUP, 32'd250, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'd300, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'd150, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'd200, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'd1_000_000_299, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'd1_000_000_300, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'd1_000_000_000, 32'd0, '0);
        send_item(MODE_ADD, 32'hFFFF_FFFF, 32'd0, {PTR_W{1'b1}});
        send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 32'd0, '0);
        send_item(MODE_LOOKUP, 32'hFFFF_FFFE, 32'd0, '0);
    endtask

    // Mostly ascending adds and lookups aimed at stored versions, with noise.
    task automatic test_version_traffic(input int n_items);
        logic [VER_W-1:0] q;
        logic [VER_W-1:0] ma;
        logic [VER_W-1:0] off;
        int               pick;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                case ($urandom_range(19))
                    0, 1:    off = '0;
                    2:       off = $urandom;
                    3:       off = WINDOW + $urandom_range(0, 4) - 2;
                    default: off = $urandom_range(1, 50);
                endcase
                q = tbl_ver[0] + off;
                case ($urandom_range(5))
                    0:       ma = '0;
                    1:       ma = 32'hFFFF_FFFF;
                    2:       ma = tbl_ver[$urandom_range(SLOT_N - 1)] + $urandom_range(1);
                    5:       ma = $urandom;
                    default: ma = tbl_ver[0] - $urandom_range(0, 300);
                endcase
                send_item(MODE_ADD, q, ma, any_pointer());
            end else if (pick < 88) begin
                case ($urandom_range(5))
                    0:       off = '0;
                    1:       off = $urandom_range(1, 100);
                    2:       off = WINDOW - 1;
                    3:       off = WINDOW;
                    4:       off = 32'hFFFF_FFFF;
                    default: off = $urandom;
                endcase
                q = tbl_ver[$urandom_range(SLOT_N - 1)] + off;
                send_item(MODE_LOOKUP, q, $urandom, any_pointer());
            end else begin
                send_item(logic'($urandom_range(1)), $urandom, $urandom, any_pointer());
            end
        end
    endtask

    task automatic test_response_stall();
        hold_req = LONG_HOLD;
        for (int n = 0; n < 20; n++) begin
            send_item(logic'($urandom_range(1)), tbl_ver[0] + $urandom_range(0, 3),
                      tbl_ver[0] - $urandom_range(0, 20), any_pointer());
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_LOOKUP;
        req_if.query_version = '0;
        req_if.min_active    = '0;
        req_if.new_pointer   = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 65;
        test_head_and_fallback();
        test_slot_reuse();
        test_ties_and_window();
        test_version_traffic(240);

        send_idle_pct = 65;
        recv_idle_pct = 10;
        test_version_traffic(240);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_response_stall();
        test_version_traffic(240);

        req_if.valid = 1'b0;
        while (owed_replies.size() != 0) @(posedge i_clk);
        repeat (4 * SLOT_N) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/vpst_pkg.sv
rtl/vpst_if.sv
rtl/vpst_slot_mem.sv
rtl/vpst_scan.sv
rtl/versioned_pointer_slot_table.sv
tb/tb.sv
